// ----- design/amgf_pkg.sv -----
// ----------------------------------------------------------------------------
// amgf_pkg: shared types and helpers for the airborne ground filter.
// Holds the slot record, altitude class codes and identifier normalization.
// ----------------------------------------------------------------------------
package amgf_pkg;

  // Default sizing of the slot table and identifier.
  localparam int unsigned SLOTS_DEFAULT    = 16;
  localparam int unsigned ID_CHARS_DEFAULT = 8;

  // Field widths fixed by the report format.
  localparam int unsigned TIME_W   = 32;
  localparam int unsigned ID_W     = 64;
  localparam int unsigned KIND_W   = 2;
  localparam int unsigned ALT_W    = 18;
  localparam logic [TIME_W-1:0] WINDOW_RESET = 32'd600;

  // Altitude class codes.
  localparam logic [KIND_W-1:0] KIND_NUMERIC   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_ON_GROUND = 2'd1;

  // One slot of the table: identifier and last airborne time.
  typedef struct packed {
    logic [ID_W-1:0]   ident;
    logic [TIME_W-1:0] seen;
  } slot_t;

  // Keeps the top n_chars characters, up to the first zero character.
  function automatic logic [ID_W-1:0] canon_id(input logic [ID_W-1:0] id,
                                               input int unsigned n_chars);
    logic [ID_W-1:0] res;
    logic            stop;
    logic [7:0]      ch;
    res  = '0;
    stop = 1'b0;
    for (int k = 0; k < 8; k++) begin
      ch = id[56-8*k +: 8];
      if (!stop && (k < n_chars) && (ch != 8'd0)) begin
        res[56-8*k +: 8] = ch;
      end else begin
        stop = 1'b1;
      end
    end
    return res;
  endfunction

endpackage

// ----- design/amgf_slot_mem.sv -----
// ----------------------------------------------------------------------------
// amgf_slot_mem: slot table storage.
// Single write port, registered read port; per-slot valid bits make a slot
// that was never written read with a seen time of zero.
// ----------------------------------------------------------------------------
module amgf_slot_mem
  import amgf_pkg::*;
#(
  parameter int unsigned SLOTS = SLOTS_DEFAULT,
  parameter int unsigned IDX_W = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             rd_en,
  input  logic [IDX_W-1:0] rd_addr,
  output slot_t            rd_data,
  input  logic             wr_en,
  input  logic [IDX_W-1:0] wr_addr,
  input  slot_t            wr_data
);

  slot_t            mem [SLOTS];
  logic [SLOTS-1:0] valid_r;
  slot_t            rd_q_r;
  logic             rd_vld_q_r;

  // Storage write and registered read.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q_r <= mem[rd_addr];
    end
  end

  // Valid bits are cleared at reset and set on every write.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r    <= '0;
      rd_vld_q_r <= 1'b0;
    end else begin
      if (wr_en) begin
        valid_r[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_vld_q_r <= valid_r[rd_addr];
      end
    end
  end

  // A slot never written reads as free.
  always_comb begin
    rd_data       = rd_q_r;
    rd_data.seen  = rd_vld_q_r ? rd_q_r.seen : '0;
  end

endmodule

// ----- design/airborne_memory_ground_filter_unit.sv -----
// ----------------------------------------------------------------------------
// airborne_memory_ground_filter_unit: ground report filter with slot table.
// Remembers aircraft recently seen airborne and drops ground reports of
// aircraft that were not.
// ----------------------------------------------------------------------------
// Usage:
//   Input transactions (in_valid/in_ready) carry one report: time, packed
//   identifier, altitude class and altitude. Each report yields one output
//   transaction (out_valid/out_ready) with out_keep.
//   cfg_we writes cfg_wdata into the window register; write only while idle.
// Sequence:
//   After acceptance the unit reads all SLOTS table entries, one per cycle
//   from the single read port, then evaluates the last entry and writes
//   back. The result is registered in the finish step together with the
//   write-back, and a new report is taken only once the unit is idle again.
// Reset:
//   rst_n (synchronous, active low) marks every slot free and sets the
//   window to 600 seconds.
// Stall:
//   A held result stays in the output register; the write-back and the next
//   result wait until the receiver takes it.
// ----------------------------------------------------------------------------
module airborne_memory_ground_filter_unit
  import amgf_pkg::*;
#(
  parameter int unsigned SLOTS    = SLOTS_DEFAULT,
  parameter int unsigned ID_CHARS = ID_CHARS_DEFAULT
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [TIME_W-1:0]       in_now_s,
  input  logic [ID_W-1:0]         in_aircraft_id,
  input  logic [KIND_W-1:0]       in_alt_kind,
  input  logic signed [ALT_W-1:0] in_altitude_ft,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic                    out_keep,
  input  logic                    cfg_we,
  input  logic [TIME_W-1:0]       cfg_wdata
);

  localparam int unsigned IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_SCAN = 4'b0010,
    ST_WAIT = 4'b0100,
    ST_FIN  = 4'b1000
  } state_t;

  state_t            state_r, state_nxt;
  logic [IDX_W-1:0]  cnt_r, cnt_nxt;
  logic [TIME_W-1:0] window_r;

  // Latched report.
  logic [TIME_W-1:0] now_r;
  logic [ID_W-1:0]   id_r;
  logic [KIND_W-1:0] kind_r;
  logic              neg_r;

  // Scan results.
  logic              eval_vld_r;
  logic [IDX_W-1:0]  eval_idx_r;
  logic              match_found_r, match_found_nxt;
  logic [IDX_W-1:0]  match_idx_r, match_idx_nxt;
  logic [TIME_W-1:0] match_time_r, match_time_nxt;
  logic              free_found_r, free_found_nxt;
  logic [IDX_W-1:0]  free_idx_r, free_idx_nxt;
  logic [IDX_W-1:0]  min_idx_r, min_idx_nxt;
  logic [TIME_W-1:0] min_time_r, min_time_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic              out_keep_r;

  logic              in_acc;
  logic              rd_en;
  slot_t             rd_data;
  logic              match_hit, free_hit;
  logic              fin_go, remember, ground, keep_val, mem_we;
  logic [IDX_W-1:0]  wr_idx;
  slot_t             wr_data;

  assign in_ready  = (state_r == ST_IDLE);
  assign in_acc    = in_valid && in_ready;
  assign rd_en     = (state_r == ST_SCAN);
  assign out_valid = out_valid_r;
  assign out_keep  = out_keep_r;

  // Slot table.
  amgf_slot_mem #(
    .SLOTS (SLOTS),
    .IDX_W (IDX_W)
  ) u_slot_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (rd_en),
    .rd_addr (cnt_r),
    .rd_data (rd_data),
    .wr_en   (mem_we),
    .wr_addr (wr_idx),
    .wr_data (wr_data)
  );

  // Window register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_r <= WINDOW_RESET;
    end else if (cfg_we) begin
      window_r <= cfg_wdata;
    end
  end

  // Sequencer: scan all slots, let the last read settle, then finish.
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    unique case (state_r)
      ST_IDLE: begin
        cnt_nxt = '0;
        if (in_acc) begin
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == LAST_IDX) begin
          state_nxt = ST_WAIT;
        end
      end
      ST_WAIT: begin
        state_nxt = ST_FIN;
      end
      ST_FIN: begin
        if (fin_go) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      eval_vld_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      eval_vld_r  <= rd_en;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Capture the report with the identifier already normalized.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      now_r  <= in_now_s;
      id_r   <= canon_id(in_aircraft_id, ID_CHARS);
      kind_r <= in_alt_kind;
      neg_r  <= in_altitude_ft[ALT_W-1];
    end
    eval_idx_r <= cnt_r;
  end

  // Per-entry evaluation: first match, first free or expired slot, oldest slot.
  assign match_hit = (rd_data.seen != '0) && (rd_data.ident == id_r);
  assign free_hit  = (rd_data.seen == '0) || ((now_r - rd_data.seen) > window_r);

  always_comb begin
    match_found_nxt = match_found_r;
    match_idx_nxt   = match_idx_r;
    match_time_nxt  = match_time_r;
    free_found_nxt  = free_found_r;
    free_idx_nxt    = free_idx_r;
    min_idx_nxt     = min_idx_r;
    min_time_nxt    = min_time_r;
    if (eval_vld_r) begin
      if (eval_idx_r == '0) begin
        match_found_nxt = match_hit;
        match_idx_nxt   = eval_idx_r;
        match_time_nxt  = rd_data.seen;
        free_found_nxt  = free_hit;
        free_idx_nxt    = eval_idx_r;
        min_idx_nxt     = eval_idx_r;
        min_time_nxt    = rd_data.seen;
      end else begin
        if (!match_found_r && match_hit) begin
          match_found_nxt = 1'b1;
          match_idx_nxt   = eval_idx_r;
          match_time_nxt  = rd_data.seen;
        end
        if (!free_found_r && free_hit) begin
          free_found_nxt = 1'b1;
          free_idx_nxt   = eval_idx_r;
        end
        if (rd_data.seen < min_time_r) begin
          min_idx_nxt  = eval_idx_r;
          min_time_nxt = rd_data.seen;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    match_found_r <= match_found_nxt;
    match_idx_r   <= match_idx_nxt;
    match_time_r  <= match_time_nxt;
    free_found_r  <= free_found_nxt;
    free_idx_r    <= free_idx_nxt;
    min_idx_r     <= min_idx_nxt;
    min_time_r    <= min_time_nxt;
  end

  // Decision and write-back once the output register is free.
  assign fin_go   = (state_r == ST_FIN) && (!out_valid_r || out_ready);
  assign remember = (now_r != '0) && (kind_r == KIND_NUMERIC) && !neg_r && (id_r != '0);
  assign ground   = (now_r != '0) && (kind_r == KIND_ON_GROUND);
  assign keep_val = ground ? ((id_r != '0) && match_found_r &&
                              ((now_r - match_time_r) <= window_r))
                           : 1'b1;
  assign mem_we   = fin_go && remember;

  always_comb begin
    priority if (match_found_r) begin
      wr_idx = match_idx_r;
    end else if (free_found_r) begin
      wr_idx = free_idx_r;
    end else begin
      wr_idx = min_idx_r;
    end
  end

  assign wr_data.ident = id_r;
  assign wr_data.seen  = now_r;

  // Output register.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (fin_go) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fin_go) begin
      out_keep_r <= keep_val;
    end
  end

`ifndef SYNTHESIS
  // The table is only written while finishing a transaction.
  a_write_in_fin: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (state_r == ST_FIN))
    else $error("slot table written outside the finish step");

  // An accepted transaction always starts a scan.
  a_accept_scan: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (state_r == ST_SCAN) && (cnt_r == '0))
    else $error("accepted transaction did not start a scan");

  // The scan ends on the last slot.
  a_scan_end: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN && cnt_r == LAST_IDX) |=> (state_r == ST_WAIT))
    else $error("scan did not end after the last slot");

  // A result only appears from the finish step.
  a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_FIN))
    else $error("result presented without a finished scan");
`endif

endmodule
